// File: hw/rtl/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

   // history ring geometry
   localparam int RING_SIZE = 1024;
   localparam int START_POS = 958;

   // longest run emitted for one beat; remainder waits for a continue
   localparam int MAX_BURST = 64;

   // match length field and bias
   localparam int LEN_BIAS = 3;

   // flag register: fresh flag byte is padded with ones above bit 7,
   // bit 8 tells whether flag bits remain after a shift
   localparam logic [15:0] FLAG_FILL = 16'hFF00;
   localparam int          FLAG_MARK = 8;

   localparam int OLEN_W = 24;

   // request codes
   typedef enum logic [1:0] {
      FUNC_BYTE  = 2'd0,
      FUNC_CONT  = 2'd1,
      FUNC_START = 2'd2
   } func_type;

   // token parser phase
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_TOKEN  = 2'd1,
      PH_MATCH2 = 2'd2
   } phase_type;

   // top level control
   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_COPY = 1'b1
   } ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/lzss_req_if.sv
`default_nettype none

// compressed byte channel
interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lzss_rsp_if.sv
`default_nettype none

// decompressed byte / status channel
interface lzss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       last;
   logic       more_pending;
   logic       done_res;
   logic       protocol_error;

   modport source (output valid, output out_byte, output out_valid, output last,
                   output more_pending, output done_res, output protocol_error,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input last,
                   input more_pending, input done_res, input protocol_error,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lzss_ring_decoder_core.sv
`default_nettype none

// LZSS decoder, 1024-byte history ring, one compressed byte per request beat.
// req_chan: func = start (clears ring, loads byte count from csr_wdata value
//   last written), byte (compressed stream byte) or continue (finish a copy
//   that was cut at 64 bytes). csr_we/csr_wdata load the output length.
// rsp_chan: every request beat yields one or more response beats; the final
//   one has last set. Status beats carry out_valid = 0.
// Output: a literal or status beat is registered and appears in the cycle
//   after acceptance. A match of n bytes streams out one byte per cycle while
//   rsp_chan does not stall, through the ring read stage and the output register;
//   the next request is taken once the last byte has left the copy pipe.
//   The rate of a match is set by the single ring read port, which is registered.
// Ring contents are never swept: a fill count marks which entries were
//   written since the last start, unwritten entries read as zero.
// Reset: synchronous, active high; count is zero so the block reports done
//   until a start beat arrives.
// Backpressure: rsp_chan has a one-beat output register; while it is held
//   the copy pipe and the request side stall, nothing is lost.
module lzss_ring_decoder_core #(
   parameter int RING_SIZE = lzss_pkg::RING_SIZE
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lzss_req_if.sink                         req_chan,
   lzss_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_we,
   input  wire logic [lzss_pkg::OLEN_W-1:0] csr_wdata
);

   localparam int AW = $clog2(RING_SIZE);
   localparam int CW = $clog2(lzss_pkg::MAX_BURST) + 1;
   localparam logic [AW-1:0] START_A  = AW'(lzss_pkg::START_POS);
   localparam logic [AW:0]   FILL_MAX = (AW+1)'(RING_SIZE);

   // architectural state
   logic [lzss_pkg::OLEN_W-1:0] olen_ff, olen_in;
   lzss_pkg::ctl_type           ctl_ff, ctl_in;
   lzss_pkg::phase_type         phase_ff, phase_in;
   logic [15:0]                 flag_ff, flag_in;
   logic [7:0]                  offlo_ff, offlo_in;
   logic [lzss_pkg::OLEN_W-1:0] rem_ff, rem_in;
   logic [1:0]                  pend_ff, pend_in;
   logic [AW-1:0]               src_ff, src_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [AW:0]                 fill_ff, fill_in;

   // copy pipe
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          s2_ff, s2_in;
   logic          hit_ff, hit_in;
   logic [7:0]    fwd_ff, fwd_in;
   logic          vld_ff, vld_in;
   logic          c_more_ff, c_more_in;
   logic          c_done_ff, c_done_in;

   // output register
   logic       o_full_ff, o_full_in;
   logic [7:0] o_byte_ff, o_byte_in;
   logic       o_ov_ff, o_ov_in;
   logic       o_last_ff, o_last_in;
   logic       o_more_ff, o_more_in;
   logic       o_done_ff, o_done_in;
   logic       o_err_ff, o_err_in;

   // decode of the request beat
   logic [15:0]                 nx_flag;
   lzss_pkg::phase_type         nx_phase;
   logic [7:0]                  nx_offlo;
   logic [lzss_pkg::OLEN_W-1:0] nx_rem;
   logic [1:0]                  nx_pend;
   logic [AW-1:0]               nx_src;
   logic                        copy_go;
   logic [CW-1:0]               run_len;
   logic                        lit;
   logic                        err;
   logic                        clear;
   logic                        tok_go;
   logic                        tok_flag;
   logic [15:0]                 shifted;
   logic [6:0]                  len_raw;
   logic [6:0]                  len_cut;
   logic [6:0]                  burst;
   logic [1:0]                  cont_cnt;

   // handshakes and ring port
   logic          acc;
   logic          out_free;
   logic          copy_on;
   logic          emit;
   logic          issue;
   logic          ring_we;
   logic [7:0]    ring_wdata;
   logic [7:0]    ram_q;
   logic [7:0]    copy_byte;
   logic [AW-1:0] ring_ofs;

   lzss_ram #(
      .WIDTH (8),
      .DEPTH (RING_SIZE)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (wp_ff),
      .wdata (ring_wdata),
      .re    (issue),
      .raddr (src_ff),
      .rdata (ram_q)
   );

   // control FSM: next state
   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         lzss_pkg::CTL_IDLE: begin
            if (acc && copy_go) begin
               ctl_in = lzss_pkg::CTL_COPY;
            end
         end
         lzss_pkg::CTL_COPY: begin
            if (emit && cnt_ff == '0) begin
               ctl_in = lzss_pkg::CTL_IDLE;
            end
         end
         default: ctl_in = lzss_pkg::CTL_IDLE;
      endcase
   end

   // control FSM: outputs
   always_comb begin
      out_free       = !o_full_ff || rsp_chan.ready;
      copy_on        = 1'b0;
      req_chan.ready = 1'b0;
      case (ctl_ff)
         lzss_pkg::CTL_IDLE: req_chan.ready = out_free;
         lzss_pkg::CTL_COPY: copy_on = 1'b1;
         default: ;
      endcase
      emit  = copy_on && s2_ff && out_free;
      issue = copy_on && cnt_ff != '0 && (!s2_ff || emit);
   end

   assign acc = req_chan.valid && req_chan.ready;

   // token parser, evaluated for the beat on the request port
   always_comb begin
      shifted  = {1'b0, flag_ff[15:1]};
      len_raw  = 7'(req_chan.in_byte[5:0]) + 7'(lzss_pkg::LEN_BIAS);
      len_cut  = (rem_ff < lzss_pkg::OLEN_W'(len_raw)) ? rem_ff[6:0] : len_raw;
      burst    = (len_cut > 7'(lzss_pkg::MAX_BURST)) ? 7'(lzss_pkg::MAX_BURST) : len_cut;
      cont_cnt = (rem_ff < lzss_pkg::OLEN_W'(pend_ff)) ? rem_ff[1:0] : pend_ff;

      nx_phase = phase_ff;
      nx_flag  = flag_ff;
      nx_offlo = offlo_ff;
      nx_rem   = rem_ff;
      nx_pend  = pend_ff;
      nx_src   = src_ff;
      copy_go  = 1'b0;
      run_len  = '0;
      lit      = 1'b0;
      err      = 1'b0;
      clear    = 1'b0;
      tok_go   = 1'b0;
      tok_flag = flag_ff[0];

      case (req_chan.func)
         lzss_pkg::FUNC_START: begin
            clear    = 1'b1;
            nx_phase = lzss_pkg::PH_START;
            nx_flag  = '0;
            nx_offlo = '0;
            nx_rem   = olen_ff;
            nx_pend  = '0;
            nx_src   = '0;
         end
         lzss_pkg::FUNC_BYTE: begin
            if (rem_ff == '0) begin
               // count reached: byte ignored
            end else if (pend_ff != '0) begin
               err = 1'b1;
            end else begin
               case (phase_ff)
                  lzss_pkg::PH_MATCH2: begin
                     nx_src   = AW'({req_chan.in_byte[7:6], offlo_ff});
                     nx_phase = lzss_pkg::PH_START;
                     nx_pend  = 2'(len_cut - burst);
                     nx_rem   = rem_ff - lzss_pkg::OLEN_W'(burst);
                     copy_go  = 1'b1;
                     run_len  = CW'(burst);
                  end
                  lzss_pkg::PH_TOKEN: begin
                     tok_go = 1'b1;
                  end
                  default: begin
                     // token start: pull a new flag byte when bits run out
                     if (!shifted[lzss_pkg::FLAG_MARK]) begin
                        nx_flag  = lzss_pkg::FLAG_FILL | 16'(req_chan.in_byte);
                        nx_phase = lzss_pkg::PH_TOKEN;
                     end else begin
                        nx_flag  = shifted;
                        tok_go   = 1'b1;
                        tok_flag = shifted[0];
                     end
                  end
               endcase
               if (tok_go) begin
                  if (tok_flag) begin
                     lit      = 1'b1;
                     nx_rem   = rem_ff - 1'b1;
                     nx_phase = lzss_pkg::PH_START;
                  end else begin
                     nx_offlo = req_chan.in_byte;
                     nx_phase = lzss_pkg::PH_MATCH2;
                  end
               end
            end
         end
         lzss_pkg::FUNC_CONT: begin
            if (rem_ff != '0 && pend_ff != '0) begin
               copy_go  = 1'b1;
               run_len  = CW'(cont_cnt);
               nx_pend  = '0;
               nx_rem   = rem_ff - lzss_pkg::OLEN_W'(cont_cnt);
            end
         end
         default: ;
      endcase
   end

   // ring write port: literal on accept, or copy byte leaving the pipe
   always_comb begin
      copy_byte  = hit_ff ? fwd_ff : (vld_ff ? ram_q : 8'h00);
      ring_we    = (acc && lit) || emit;
      ring_wdata = emit ? copy_byte : req_chan.in_byte;
      ring_ofs   = src_ff - START_A;
   end

   // next state of parser, pointers and copy pipe
   always_comb begin
      olen_in   = csr_we ? csr_wdata : olen_ff;
      phase_in  = phase_ff;
      flag_in   = flag_ff;
      offlo_in  = offlo_ff;
      rem_in    = rem_ff;
      pend_in   = pend_ff;
      src_in    = src_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      c_more_in = c_more_ff;
      c_done_in = c_done_ff;

      if (acc) begin
         phase_in = nx_phase;
         flag_in  = nx_flag;
         offlo_in = nx_offlo;
         rem_in   = nx_rem;
         pend_in  = nx_pend;
         src_in   = nx_src;
         if (copy_go) begin
            cnt_in    = run_len;
            c_more_in = nx_pend != '0;
            c_done_in = nx_rem == '0;
         end
      end

      if (issue) begin
         src_in = src_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end

      if (acc && clear) begin
         wp_in   = START_A;
         fill_in = '0;
      end else if (ring_we) begin
         wp_in = wp_ff + 1'b1;
         if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      // read stage: forward a same-entry write, mask never-written entries
      s2_in  = issue ? 1'b1 : (emit ? 1'b0 : s2_ff);
      hit_in = hit_ff;
      fwd_in = fwd_ff;
      vld_in = vld_ff;
      if (issue) begin
         hit_in = ring_we && wp_ff == src_ff;
         fwd_in = ring_wdata;
         vld_in = {1'b0, ring_ofs} < fill_ff;
      end
   end

   // output register
   always_comb begin
      o_full_in = o_full_ff;
      o_byte_in = o_byte_ff;
      o_ov_in   = o_ov_ff;
      o_last_in = o_last_ff;
      o_more_in = o_more_ff;
      o_done_in = o_done_ff;
      o_err_in  = o_err_ff;
      if (acc && !copy_go) begin
         o_full_in = 1'b1;
         o_byte_in = lit ? req_chan.in_byte : 8'h00;
         o_ov_in   = lit;
         o_last_in = 1'b1;
         o_more_in = nx_pend != '0;
         o_done_in = nx_rem == '0;
         o_err_in  = err;
      end else if (emit) begin
         o_full_in = 1'b1;
         o_byte_in = copy_byte;
         o_ov_in   = 1'b1;
         o_last_in = cnt_ff == '0;
         o_more_in = c_more_ff;
         o_done_in = c_done_ff;
         o_err_in  = 1'b0;
      end else if (rsp_chan.ready) begin
         o_full_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         olen_ff   <= '0;
         ctl_ff    <= lzss_pkg::CTL_IDLE;
         phase_ff  <= lzss_pkg::PH_START;
         flag_ff   <= '0;
         offlo_ff  <= '0;
         rem_ff    <= '0;
         pend_ff   <= '0;
         src_ff    <= '0;
         wp_ff     <= START_A;
         fill_ff   <= '0;
         cnt_ff    <= '0;
         s2_ff     <= 1'b0;
         o_full_ff <= 1'b0;
      end else begin
         olen_ff   <= olen_in;
         ctl_ff    <= ctl_in;
         phase_ff  <= phase_in;
         flag_ff   <= flag_in;
         offlo_ff  <= offlo_in;
         rem_ff    <= rem_in;
         pend_ff   <= pend_in;
         src_ff    <= src_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
         s2_ff     <= s2_in;
         o_full_ff <= o_full_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff    <= hit_in;
      fwd_ff    <= fwd_in;
      vld_ff    <= vld_in;
      c_more_ff <= c_more_in;
      c_done_ff <= c_done_in;
      o_byte_ff <= o_byte_in;
      o_ov_ff   <= o_ov_in;
      o_last_ff <= o_last_in;
      o_more_ff <= o_more_in;
      o_done_ff <= o_done_in;
      o_err_ff  <= o_err_in;
   end

   assign rsp_chan.valid          = o_full_ff;
   assign rsp_chan.out_byte       = o_byte_ff;
   assign rsp_chan.out_valid      = o_ov_ff;
   assign rsp_chan.last           = o_last_ff;
   assign rsp_chan.more_pending   = o_more_ff;
   assign rsp_chan.done_res       = o_done_ff;
   assign rsp_chan.protocol_error = o_err_ff;

   // no copy bytes in flight while idle
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      ctl_ff == lzss_pkg::CTL_IDLE |-> (!s2_ff && cnt_ff == '0))
      else $error("copy pipe busy while idle");

   // a started copy always has at least one byte to move
   a_copy_nonzero: assert property (@(posedge clock) disable iff (reset)
      acc && copy_go |=> (ctl_ff == lzss_pkg::CTL_COPY && (cnt_ff != '0 || s2_ff)))
      else $error("empty copy started");

   // leftover after a burst never exceeds two bytes
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("pending count out of range");

   // fill count saturates at the ring size
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count overflow");

   // the last copy byte carries last and returns control to idle
   a_copy_end: assert property (@(posedge clock) disable iff (reset)
      emit && cnt_ff == '0 |=> (ctl_ff == lzss_pkg::CTL_IDLE && o_full_ff && o_last_ff))
      else $error("copy did not close with last");

endmodule

`default_nettype wire

// File: hw/rtl/lzss_ram.sv
`default_nettype none

// simple dual port RAM, one write and one registered read per cycle;
// a read of the address being written returns the old contents
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;

   // unused request code, must come back as a plain status beat
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int TARGET_ITEMS = 450;
   localparam int SETTLE_CYCLES = 8;

   // one response beat as seen on rsp_chan
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       last;
      logic       more_pending;
      logic       done_res;
      logic       protocol_error;
   } rsp_beat_type;

   // Decoder image: tracks ring, parser and byte count, queues the beats
   // each accepted request must produce.
   class decode_scoreboard;
      logic [7:0]          hist [lzss_pkg::RING_SIZE];
      logic [9:0]          wpos;
      logic [15:0]         flags;
      lzss_pkg::phase_type phase;
      logic [7:0]          off_lo;
      logic [23:0]         remaining;
      logic [1:0]          pend;
      logic [9:0]          src;
      logic [23:0]         olen;
      logic [7:0]          emitted [$];
      rsp_beat_type        expected_beats [$];
      int                  errors;

      function new();
         clear_stream();
         remaining = '0;
         olen      = '0;
         errors    = 0;
      endfunction

      function void clear_stream();
         foreach (hist[i]) hist[i] = 8'h00;
         wpos   = 10'(lzss_pkg::START_POS);
         flags  = '0;
         phase  = lzss_pkg::PH_START;
         off_lo = '0;
         pend   = '0;
         src    = '0;
      endfunction

      function void set_length(logic [23:0] v);
         olen = v;
      endfunction

      // every emitted byte also lands in the ring
      function void put_byte(logic [7:0] v);
         hist[wpos] = v;
         wpos = wpos + 10'd1;
         emitted.push_back(v);
      endfunction

      function void copy_run(int cnt);
         logic [7:0] v;
         for (int i = 0; i < cnt; i++) begin
            v = hist[src];
            src = src + 10'd1;
            put_byte(v);
            if (remaining != 0) remaining = remaining - 24'd1;
         end
      endfunction

      // first byte of a token: literal, or low offset of a match
      function void token_byte(logic [7:0] b);
         if (flags[0]) begin
            put_byte(b);
            remaining = remaining - 24'd1;
            phase = lzss_pkg::PH_START;
         end else begin
            off_lo = b;
            phase = lzss_pkg::PH_MATCH2;
         end
      endfunction

      function void parse_byte(logic [7:0] b);
         int len;
         int burst;
         if (phase == lzss_pkg::PH_MATCH2) begin
            len = int'(b[5:0]) + lzss_pkg::LEN_BIAS;
            src = {b[7:6], off_lo};
            if (len > int'(remaining)) len = int'(remaining);
            burst = (len > lzss_pkg::MAX_BURST) ? lzss_pkg::MAX_BURST : len;
            pend = 2'(len - burst);
            phase = lzss_pkg::PH_START;
            copy_run(burst);
         end else if (phase == lzss_pkg::PH_TOKEN) begin
            token_byte(b);
         end else begin
            // shift out the used flag; bit 8 clear means a new flag byte
            flags = flags >> 1;
            if (!flags[lzss_pkg::FLAG_MARK]) begin
               flags = lzss_pkg::FLAG_FILL | {8'h00, b};
               phase = lzss_pkg::PH_TOKEN;
            end else begin
               token_byte(b);
            end
         end
      endfunction

      // work out the beats caused by one accepted request
      function void decode_request(logic [1:0] f, logic [7:0] b);
         logic         err;
         int           cnt;
         bit           status;
         rsp_beat_type beat;
         err = 1'b0;
         emitted.delete();
         case (f)
            lzss_pkg::FUNC_START: begin
               clear_stream();
               remaining = olen;
            end
            lzss_pkg::FUNC_BYTE: begin
               if (remaining == 0) begin
                  // count reached, byte ignored
               end else if (pend != 0) begin
                  err = 1'b1;
               end else begin
                  parse_byte(b);
               end
            end
            lzss_pkg::FUNC_CONT: begin
               if (remaining != 0 && pend != 0) begin
                  cnt = pend;
                  if (cnt > int'(remaining)) cnt = int'(remaining);
                  pend = '0;
                  copy_run(cnt);
               end
            end
            default: ;
         endcase
         // a status beat carries no byte
         status = (emitted.size() == 0);
         if (status) emitted.push_back(8'h00);
         for (int k = 0; k < emitted.size(); k++) begin
            beat.out_byte       = emitted[k];
            beat.out_valid      = !status;
            beat.last           = (k == emitted.size() - 1);
            beat.more_pending   = (pend != 0);
            beat.done_res       = (remaining == 0);
            beat.protocol_error = err;
            expected_beats.push_back(beat);
         end
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR @%0t: %s", $time, msg);
      endtask

      task check_field(string name, int got, int want);
         if (got != want)
            report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat %0h", got));
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", got.out_byte, want.out_byte);
            check_field("out_valid", got.out_valid, want.out_valid);
            check_field("last", got.last, want.last);
            check_field("more_pending", got.more_pending, want.more_pending);
            check_field("done_res", got.done_res, want.done_res);
            check_field("protocol_error", got.protocol_error, want.protocol_error);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [lzss_pkg::OLEN_W-1:0] csr_wdata;

   lzss_req_if req ();
   lzss_rsp_if rsp ();

   lzss_ring_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   decode_scoreboard sb = new();
   int req_gap_max = 5;
   int rsp_gap_max = 5;
   int items_sent  = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // known values from the start
   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      req.valid     <= 1'b0;
      req.func      <= lzss_pkg::FUNC_BYTE;
      req.in_byte   <= 8'h00;
      rsp.ready     <= 1'b0;
   end

   // one request beat; valid stays up if the next beat follows at once
   task automatic send_req(input logic [1:0] f, input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.func    <= f;
      req.in_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.decode_request(f, b);
      items_sent++;
   endtask

   // let every expected beat drain before touching the length register
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length(input logic [23:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_length(v);
      csr_we    <= 1'b0;
   endtask

   // match token: mostly short reach-back, sometimes anywhere in the ring
   task automatic send_match();
      logic [9:0] off;
      logic [5:0] len_field;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) off = sb.wpos - 10'($urandom_range(1, 80));
      else off = 10'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) len_field = 6'($urandom_range(0, 13));
      else if (pick < 85) len_field = 6'($urandom_range(61, 63));
      else len_field = 6'($urandom);
      send_req(lzss_pkg::FUNC_BYTE, off[7:0]);
      send_req(lzss_pkg::FUNC_BYTE, {off[9:8], len_field});
      if (sb.pend != 0) begin
         // occasionally push a byte into the pending copy
         if ($urandom_range(0, 9) == 0) send_req(lzss_pkg::FUNC_BYTE, 8'($urandom));
         send_req(lzss_pkg::FUNC_CONT, 8'($urandom));
      end
   endtask

   // flag byte plus up to eight tokens, repeated; a little noise mixed in
   task automatic send_tokens(input int ntok);
      logic [7:0] flag;
      while (ntok > 0 && sb.remaining != 0) begin
         flag = 8'($urandom);
         send_req(lzss_pkg::FUNC_BYTE, flag);
         for (int i = 0; i < 8 && ntok > 0 && sb.remaining != 0; i++) begin
            ntok--;
            if ($urandom_range(0, 99) < 4)
               send_req(2'($urandom_range(0, 3)), 8'($urandom));
            if (flag[i]) send_req(lzss_pkg::FUNC_BYTE, 8'($urandom));
            else send_match();
         end
      end
      // a few beats past the end of the count
      if (sb.remaining == 0) begin
         repeat ($urandom_range(0, 2))
            send_req($urandom_range(0, 1) ? lzss_pkg::FUNC_BYTE : lzss_pkg::FUNC_CONT,
                     8'($urandom));
      end
   endtask

   // response side: random stalls, compare every accepted beat
   initial begin
      int gap;
      rsp_beat_type got;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap != 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got.out_byte       = rsp.out_byte;
         got.out_valid      = rsp.out_valid;
         got.last           = rsp.last;
         got.more_pending   = rsp.more_pending;
         got.done_res       = rsp.done_res;
         got.protocol_error = rsp.protocol_error;
         sb.check_result(got);
      end
   end

   // stimulus
   initial begin
      logic [23:0] len;
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing started yet: everything reports done
      send_req(lzss_pkg::FUNC_BYTE, 8'hFF);
      send_req(lzss_pkg::FUNC_CONT, 8'h00);
      send_req(FUNC_UNUSED, 8'h5A);

      // full-length stream: literals, longest overlapping match, cut burst
      wait_idle();
      write_length(24'hFFFFFF);
      send_req(lzss_pkg::FUNC_START, 8'h00);
      send_req(lzss_pkg::FUNC_BYTE, 8'b1111_0011);
      send_req(lzss_pkg::FUNC_BYTE, 8'h00);
      send_req(lzss_pkg::FUNC_BYTE, 8'hFF);
      send_req(lzss_pkg::FUNC_BYTE, 8'hBE);
      send_req(lzss_pkg::FUNC_BYTE, {2'b11, 6'h3F});
      send_req(lzss_pkg::FUNC_BYTE, 8'hA5);     // dropped: copy still pending
      send_req(lzss_pkg::FUNC_CONT, 8'h00);
      send_req(lzss_pkg::FUNC_CONT, 8'hFF);     // nothing pending
      send_req(lzss_pkg::FUNC_BYTE, 8'h00);
      send_req(lzss_pkg::FUNC_BYTE, 8'h00);
      send_req(lzss_pkg::FUNC_BYTE, 8'h5A);

      // match running past the byte count
      wait_idle();
      write_length(24'd5);
      send_req(lzss_pkg::FUNC_START, 8'hFF);
      send_req(lzss_pkg::FUNC_BYTE, 8'h01);
      send_req(lzss_pkg::FUNC_BYTE, 8'h11);
      send_req(lzss_pkg::FUNC_BYTE, 8'hBE);
      send_req(lzss_pkg::FUNC_BYTE, {2'b11, 6'h3F});
      send_req(lzss_pkg::FUNC_BYTE, 8'h77);
      send_req(lzss_pkg::FUNC_CONT, 8'h00);

      // empty stream
      wait_idle();
      write_length(24'd0);
      send_req(lzss_pkg::FUNC_START, 8'h00);
      send_req(lzss_pkg::FUNC_BYTE, 8'h3C);

      // random streams, with bursts of no idling on either side
      while (items_sent < TARGET_ITEMS) begin
         wait_idle();
         pick = $urandom_range(0, 19);
         if (pick == 0) len = 24'd0;
         else if (pick == 1) len = 24'hFFFFFF;
         else if (pick < 5) len = 24'($urandom);
         else len = 24'($urandom_range(8, 300));
         write_length(len);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         send_req(lzss_pkg::FUNC_START, 8'($urandom));
         send_tokens($urandom_range(10, 60));
         // new length mid-stream only counts from the next start
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_length(24'($urandom_range(0, 400)));
            send_tokens($urandom_range(5, 30));
         end
      end

      // drain and settle
      req.valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("lzss_ring_decoder_core verification clean");
      else
         $display("lzss_ring_decoder_core verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("lzss_ring_decoder_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_req_if.sv
hw/rtl/lzss_rsp_if.sv
hw/rtl/lzss_ram.sv
hw/rtl/lzss_ring_decoder_core.sv
sim/testbench.sv
